// ===== hdl/vdi_pkg.sv =====
// Package for the vertex dedup indexer: transaction types and constants.
// No dependencies.
package vdi_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int INDEX_W        = 10;
    localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic        mesh_start;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               table_full;
    } out_item_t;

    function automatic logic [31:0] canon_coord(input logic [31:0] v);
        return (v == NEG_ZERO) ? 32'h0 : v;
    endfunction

endpackage

// ===== hdl/vertex_dedup_indexer_core.sv =====
// Vertex dedup indexer top level: welds vertices into an index buffer.
// Depends on vdi_pkg, vdi_front, vdi_back.
//
// Input channel: push/full with in_data (x, y, z bit patterns, mesh_start).
// A transaction is taken when push is high and full is low. A two-entry
// queue holds taken transactions while the search unit is busy.
// Result channel: empty/pop with out_data (vertex_index, is_new,
// table_full). The oldest result is shown while empty is low and leaves
// when pop is high. A two-entry result queue holds finished results.
// The search unit takes one vertex at a time, scanning the N entries filled
// since the last mesh start before it takes the next; the table is one
// memory with one read port, scanned one entry per cycle. -0 and +0 compare
// equal; NaN matches bit-exact.
// Reset empties both queues and the table; no clearing pass is needed,
// the fill count marks which entries are live. When the receiver stalls
// the result queue fills, the search unit waits, then full rises.
module vertex_dedup_indexer_core #(
    parameter int TABLE_SIZE = vdi_pkg::TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vdi_pkg::in_item_t  in_data,
    output logic               empty,
    input  logic               pop,
    output vdi_pkg::out_item_t out_data
);

    logic              item_valid;
    logic              item_take;
    vdi_pkg::in_item_t item;

    vdi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    vdi_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .out_data   (out_data)
    );

endmodule

// ===== hdl/vdi_front.sv =====
// Front end: accepts vertex transactions, folds -0 to +0 and queues them.
// Depends on vdi_pkg.
module vdi_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  vdi_pkg::in_item_t in_data,
    output logic             item_valid,
    input  logic             item_take,
    output vdi_pkg::in_item_t item
);

    vdi_pkg::in_item_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_ptr_reg, wr_ptr_reg;
    logic       do_push, do_pop;
    vdi_pkg::in_item_t canon;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        canon            = in_data;
        canon.coord_x    = vdi_pkg::canon_coord(in_data.coord_x);
        canon.coord_y    = vdi_pkg::canon_coord(in_data.coord_y);
        canon.coord_z    = vdi_pkg::canon_coord(in_data.coord_z);
        cnt_next         = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= canon;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

// ===== hdl/vdi_back.sv =====
// Back end: linear search of the vertex table, insert, result queue.
// Depends on vdi_pkg.
module vdi_back #(
    parameter int TABLE_SIZE = vdi_pkg::TABLE_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_take,
    input  vdi_pkg::in_item_t item,
    output logic              empty,
    input  logic              pop,
    output vdi_pkg::out_item_t out_data
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] LIMIT = CW'(TABLE_SIZE);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic [95:0] mem [TABLE_SIZE];
    logic [95:0] rdata_reg;

    logic          state_reg, state_next;
    logic [CW-1:0] next_id_reg, next_id_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] cmp_id_reg, cmp_id_next;
    logic          pend_reg, pend_next;
    logic [95:0]   key_reg;
    logic          ld_key, rd_en, wr_en, hit, res_push;
    vdi_pkg::out_item_t res;

    vdi_pkg::out_item_t oq_reg [2];
    logic [1:0] ocnt_reg;
    logic       ord_reg, owr_reg, res_pop;

    assign hit = pend_reg && (rdata_reg == key_reg);

    always_comb
    begin
        state_next   = state_reg;
        next_id_next = next_id_reg;
        scan_next    = scan_reg;
        cmp_id_next  = cmp_id_reg;
        pend_next    = 1'b0;
        ld_key       = 1'b0;
        item_take    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        res_push     = 1'b0;
        res          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && ocnt_reg != 2'd2)
                begin
                    item_take  = 1'b1;
                    ld_key     = 1'b1;
                    scan_next  = '0;
                    state_next = ST_SCAN;
                    if (item.mesh_start)
                    begin
                        next_id_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_push         = 1'b1;
                    res.vertex_index = vdi_pkg::INDEX_W'(cmp_id_reg);
                    state_next       = ST_IDLE;
                end
                else if (scan_reg < next_id_reg)
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    cmp_id_next = scan_reg;
                    scan_next   = scan_reg + 1'b1;
                end
                else
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                    if (next_id_reg == LIMIT)
                    begin
                        res.table_full = 1'b1;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        res.is_new       = 1'b1;
                        res.vertex_index = vdi_pkg::INDEX_W'(next_id_reg);
                        next_id_next     = next_id_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld_key)
        begin
            key_reg <= {item.coord_x, item.coord_y, item.coord_z};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[scan_reg[IW-1:0]];
        end
        if (wr_en)
        begin
            mem[next_id_reg[IW-1:0]] <= key_reg;
        end
        if (res_push)
        begin
            oq_reg[owr_reg] <= res;
        end
    end

    assign empty    = (ocnt_reg == 2'd0);
    assign out_data = oq_reg[ord_reg];
    assign res_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            next_id_reg <= '0;
            scan_reg    <= '0;
            cmp_id_reg  <= '0;
            pend_reg    <= 1'b0;
            ocnt_reg    <= 2'd0;
            ord_reg     <= 1'b0;
            owr_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            next_id_reg <= next_id_next;
            scan_reg    <= scan_next;
            cmp_id_reg  <= cmp_id_next;
            pend_reg    <= pend_next;
            ocnt_reg    <= ocnt_reg + {1'b0, res_push} - {1'b0, res_pop};
            if (res_push)
            begin
                owr_reg <= !owr_reg;
            end
            if (res_pop)
            begin
                ord_reg <= !ord_reg;
            end
        end
    end

    a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3)
        else $error("result queue overflow");

    a_next_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg <= LIMIT)
        else $error("next id beyond table");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_reg <= next_id_reg)
        else $error("scan beyond filled entries");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (ocnt_reg != 2'd2 || res_pop))
        else $error("result pushed into full queue");

endmodule
